// ----- hw/rtl/dstq_pkg.sv -----
package dstq_pkg;

  localparam int unsigned DL_W   = 48;
  localparam int unsigned IV_W   = 32;
  localparam int unsigned ID_W   = 8;
  localparam int unsigned MIN_W  = 16;
  localparam int unsigned KIND_W = 3;

  localparam logic [DL_W-1:0] DL_MAX = {DL_W{1'b1}};
  // 0.01 s expressed in milliseconds.
  localparam logic [MIN_W-1:0] MIN_INTERVAL_RST = 16'd10;

  typedef enum logic [1:0] {
    ACT_START    = 2'd0,
    ACT_STOP     = 2'd1,
    ACT_STOP_ALL = 2'd2,
    ACT_TICK     = 2'd3
  } action_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_STARTED   = 3'd0,
    KIND_REJECTED  = 3'd1,
    KIND_STOPPED   = 3'd2,
    KIND_NOT_FOUND = 3'd3,
    KIND_CLEARED   = 3'd4,
    KIND_FIRED     = 3'd5,
    KIND_NONE_DUE  = 3'd6
  } kind_e;

  // One queue entry as held in the entry memory.
  typedef struct packed {
    logic [DL_W-1:0] deadline;
    logic [IV_W-1:0] interval;
    logic [ID_W-1:0] id;
    logic            recurring;
    logic            on_main;
  } entry_t;

  typedef struct packed {
    kind_e           kind;
    logic [ID_W-1:0] id;
    logic            on_main;
    logic            head;
    logic            last;
  } result_t;

endpackage

// ----- hw/rtl/dstq_rearm.sv -----
module dstq_rearm
  import dstq_pkg::*;
(
  input  logic [DL_W-1:0]  deadline_i,
  input  logic [IV_W-1:0]  interval_i,
  input  logic [MIN_W-1:0] min_interval_i,
  output logic [DL_W-1:0]  next_deadline_o
);

  logic [IV_W-1:0] step;
  logic [DL_W:0]   sum;

  // The period is raised to the configured minimum, and the new deadline
  // saturates at the largest representable time.
  always_comb begin
    if (interval_i < IV_W'(min_interval_i)) begin
      step = IV_W'(min_interval_i);
    end else begin
      step = interval_i;
    end
    sum = {1'b0, deadline_i} + (DL_W + 1)'(step);
    if (sum[DL_W]) begin
      next_deadline_o = DL_MAX;
    end else begin
      next_deadline_o = sum[DL_W-1:0];
    end
  end

endmodule

// ----- hw/rtl/deadline_sorted_timer_queue.sv -----
// Sorted deadline timer queue. Timers are kept in a single entry memory
// ordered by deadline, with equal deadlines in arrival order. A command is
// taken when start is high and busy is low; busy then stays high until the
// command's last result has been produced. Every result appears for exactly
// one cycle with result_valid_o high and cannot be held off, so the receiver
// must take it in that cycle; last_o marks the final result of a command.
// All work goes through one memory read port and one write port, moving one
// entry per cycle. A start walks from the tail, moving each entry that sorts
// after the new timer down one place; a stop scans the queue from the head.
// A stop-all, a rejected start and a stop on an empty queue are answered
// without busy going high. A tick inspects the head, then for every fired
// timer closes the gap at the head and reinserts a recurring timer. A tick
// fires at most MAX_FIRES_PER_TICK timers; the rest stay due. The
// min_interval register may be written only while busy is low.
module deadline_sorted_timer_queue
  import dstq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH        = 16,
  parameter int unsigned MAX_FIRES_PER_TICK = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              cfg_we_i,
  input  logic [MIN_W-1:0]  cfg_wdata_i,

  input  logic              start,
  output logic              busy,
  input  logic [1:0]        action_i,
  input  logic [ID_W-1:0]   timer_id_i,
  input  logic [DL_W-1:0]   first_deadline_i,
  input  logic [IV_W-1:0]   interval_i,
  input  logic              recurring_i,
  input  logic              on_main_i,
  input  logic [DL_W-1:0]   now_time_i,

  output logic              result_valid_o,
  output logic [KIND_W-1:0] kind_o,
  output logic [ID_W-1:0]   out_timer_id_o,
  output logic              deliver_on_main_o,
  output logic              became_head_o,
  output logic              last_o
);

  localparam int unsigned IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned FIRE_W = $clog2(MAX_FIRES_PER_TICK + 1);

  localparam logic [CNT_W-1:0]  DEPTH_C     = CNT_W'(QUEUE_DEPTH);
  localparam logic [FIRE_W-1:0] MAX_FIRES_C = FIRE_W'(MAX_FIRES_PER_TICK);

  // Sequencer states. Insertion walks from the tail toward the head,
  // moving each later entry down one place until the new timer's slot is
  // found. The scan walks from a start index toward the tail and, once the
  // entry to drop is behind it, moves each entry up one place.
  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_INS_RD   = 7'b0000010,
    ST_INS_CMP  = 7'b0000100,
    ST_INS_WR   = 7'b0001000,
    ST_SCAN     = 7'b0010000,
    ST_TCK_REQ  = 7'b0100000,
    ST_TCK_HEAD = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  action_e           op_q, op_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              found_q, found_d;
  logic [FIRE_W-1:0] fires_q, fires_d;
  logic [ID_W-1:0]   key_id_q, key_id_d;
  logic [DL_W-1:0]   now_q, now_d;
  entry_t            ins_q, ins_d;
  logic              pend_valid_q, pend_valid_d;
  logic [ID_W-1:0]   pend_id_q, pend_id_d;
  logic              pend_main_q, pend_main_d;
  logic [MIN_W-1:0]  min_int_q;
  logic              res_valid_q, res_valid_d;
  result_t           res_q, res_d;

  // Entry memory: one read and one write per cycle, registered read data.
  entry_t            mem_q [QUEUE_DEPTH];
  entry_t            rdata_q;
  logic [IDX_W-1:0]  mem_raddr;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;

  // Shared deadline comparator: against now during a head check, against
  // the timer being inserted otherwise.
  logic [DL_W-1:0]   cmp_key;
  logic              rd_le_key;
  logic [DL_W-1:0]   rearm_dl;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  assign cmp_key   = (state_q == ST_TCK_HEAD) ? now_q : ins_q.deadline;
  assign rd_le_key = (rdata_q.deadline <= cmp_key);

  dstq_rearm u_rearm (
    .deadline_i      (rdata_q.deadline),
    .interval_i      (rdata_q.interval),
    .min_interval_i  (min_int_q),
    .next_deadline_o (rearm_dl)
  );

  assign busy = (state_q != ST_IDLE);

  always_comb begin
    logic             scan_last;
    logic             hit;
    logic [CNT_W-1:0] cnt_dec;

    state_d      = state_q;
    op_d         = op_q;
    count_d      = count_q;
    idx_d        = idx_q;
    found_d      = found_q;
    fires_d      = fires_q;
    key_id_d     = key_id_q;
    now_d        = now_q;
    ins_d        = ins_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    pend_main_d  = pend_main_q;
    res_valid_d  = 1'b0;
    res_d        = res_q;
    mem_raddr    = idx_q;
    mem_we       = 1'b0;
    mem_waddr    = idx_q;
    mem_wdata    = ins_q;

    scan_last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
    hit       = found_q || (rdata_q.id == key_id_q);
    cnt_dec   = count_q - CNT_W'(1);

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          op_d     = action_e'(action_i);
          key_id_d = timer_id_i;
          unique case (action_e'(action_i))
            ACT_START: begin
              if (count_q == DEPTH_C) begin
                res_valid_d = 1'b1;
                res_d       = '{KIND_REJECTED, timer_id_i, 1'b0, 1'b0, 1'b1};
              end else begin
                ins_d = '{first_deadline_i, interval_i, timer_id_i,
                          recurring_i, on_main_i};
                idx_d = count_q[IDX_W-1:0];
                if (count_q == '0) begin
                  state_d = ST_INS_WR;
                end else begin
                  state_d = ST_INS_RD;
                end
              end
            end
            ACT_STOP: begin
              if (count_q == '0) begin
                res_valid_d = 1'b1;
                res_d       = '{KIND_NOT_FOUND, timer_id_i, 1'b0, 1'b0, 1'b1};
              end else begin
                idx_d     = '0;
                found_d   = 1'b0;
                mem_raddr = '0;
                state_d   = ST_SCAN;
              end
            end
            ACT_STOP_ALL: begin
              count_d     = '0;
              res_valid_d = 1'b1;
              res_d       = '{KIND_CLEARED, '0, 1'b0, 1'b0, 1'b1};
            end
            ACT_TICK: begin
              now_d        = now_time_i;
              fires_d      = '0;
              pend_valid_d = 1'b0;
              state_d      = ST_TCK_REQ;
            end
          endcase
        end
      end

      ST_INS_RD: begin
        mem_raddr = idx_q - IDX_W'(1);
        state_d   = ST_INS_CMP;
      end

      ST_INS_CMP: begin
        // rdata_q holds the entry just above slot idx_q.
        mem_we = 1'b1;
        if (rd_le_key) begin
          mem_wdata = ins_q;
          count_d   = count_q + CNT_W'(1);
          if (op_q == ACT_TICK) begin
            state_d = ST_TCK_REQ;
          end else begin
            res_valid_d = 1'b1;
            res_d       = '{KIND_STARTED, ins_q.id, 1'b0, (idx_q == '0), 1'b1};
            state_d     = ST_IDLE;
          end
        end else begin
          mem_wdata = rdata_q;
          idx_d     = idx_q - IDX_W'(1);
          mem_raddr = idx_q - IDX_W'(2);
          if (idx_q == IDX_W'(1)) begin
            state_d = ST_INS_WR;
          end
        end
      end

      ST_INS_WR: begin
        mem_we    = 1'b1;
        mem_wdata = ins_q;
        count_d   = count_q + CNT_W'(1);
        if (op_q == ACT_TICK) begin
          state_d = ST_TCK_REQ;
        end else begin
          res_valid_d = 1'b1;
          res_d       = '{KIND_STARTED, ins_q.id, 1'b0, (idx_q == '0), 1'b1};
          state_d     = ST_IDLE;
        end
      end

      ST_SCAN: begin
        // rdata_q holds entry idx_q; the next one is fetched meanwhile.
        if (!scan_last) begin
          mem_raddr = idx_q + IDX_W'(1);
        end
        if (found_q) begin
          mem_we    = 1'b1;
          mem_waddr = idx_q - IDX_W'(1);
          mem_wdata = rdata_q;
        end
        found_d = hit;
        idx_d   = idx_q + IDX_W'(1);
        if (scan_last) begin
          if (op_q == ACT_TICK) begin
            count_d = cnt_dec;
            if (ins_q.recurring) begin
              idx_d   = cnt_dec[IDX_W-1:0];
              state_d = ST_INS_RD;
            end else begin
              state_d = ST_TCK_REQ;
            end
          end else begin
            res_valid_d = 1'b1;
            if (hit) begin
              count_d = cnt_dec;
              res_d   = '{KIND_STOPPED, key_id_q, 1'b0, 1'b0, 1'b1};
            end else begin
              res_d   = '{KIND_NOT_FOUND, key_id_q, 1'b0, 1'b0, 1'b1};
            end
            state_d = ST_IDLE;
          end
        end
      end

      ST_TCK_REQ: begin
        if ((count_q == '0) || (fires_q == MAX_FIRES_C)) begin
          res_valid_d = 1'b1;
          if (pend_valid_q) begin
            res_d = '{KIND_FIRED, pend_id_q, pend_main_q, 1'b0, 1'b1};
          end else begin
            res_d = '{KIND_NONE_DUE, '0, 1'b0, 1'b0, 1'b1};
          end
          state_d = ST_IDLE;
        end else begin
          mem_raddr = '0;
          state_d   = ST_TCK_HEAD;
        end
      end

      ST_TCK_HEAD: begin
        if (!rd_le_key) begin
          res_valid_d = 1'b1;
          if (pend_valid_q) begin
            res_d = '{KIND_FIRED, pend_id_q, pend_main_q, 1'b0, 1'b1};
          end else begin
            res_d = '{KIND_NONE_DUE, '0, 1'b0, 1'b0, 1'b1};
          end
          state_d = ST_IDLE;
        end else begin
          // The head is due. The previous fire is released now that it is
          // known not to be the last one; this one waits its turn.
          if (pend_valid_q) begin
            res_valid_d = 1'b1;
            res_d       = '{KIND_FIRED, pend_id_q, pend_main_q, 1'b0, 1'b0};
          end
          pend_valid_d = 1'b1;
          pend_id_d    = rdata_q.id;
          pend_main_d  = rdata_q.on_main;
          fires_d      = fires_q + FIRE_W'(1);
          ins_d        = '{rearm_dl, rdata_q.interval, rdata_q.id,
                           rdata_q.recurring, rdata_q.on_main};
          if (count_q == CNT_W'(1)) begin
            count_d = '0;
            idx_d   = '0;
            if (rdata_q.recurring) begin
              state_d = ST_INS_WR;
            end else begin
              state_d = ST_TCK_REQ;
            end
          end else begin
            idx_d     = IDX_W'(1);
            found_d   = 1'b1;
            mem_raddr = IDX_W'(1);
            state_d   = ST_SCAN;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      fires_q      <= '0;
      pend_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
      min_int_q    <= MIN_INTERVAL_RST;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      fires_q      <= fires_d;
      pend_valid_q <= pend_valid_d;
      res_valid_q  <= res_valid_d;
      if (cfg_we_i) begin
        min_int_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    idx_q       <= idx_d;
    found_q     <= found_d;
    key_id_q    <= key_id_d;
    now_q       <= now_d;
    ins_q       <= ins_d;
    pend_id_q   <= pend_id_d;
    pend_main_q <= pend_main_d;
    res_q       <= res_d;
  end

  assign result_valid_o    = res_valid_q;
  assign kind_o            = res_q.kind;
  assign out_timer_id_o    = res_q.id;
  assign deliver_on_main_o = res_q.on_main;
  assign became_head_o     = res_q.head;
  assign last_o            = res_q.last;

  // The queue never holds more timers than it has slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("entry count exceeds queue depth");

  // A tick never counts more fires than its limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fires_q <= MAX_FIRES_C)
    else $error("fire count exceeds limit");

  // Only fires can be followed by further results of the same item, and the
  // block must still be working on that item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.last) |-> (res_q.kind == KIND_FIRED) && busy)
    else $error("non-final result that is not a fire or while idle");

  // The head flag belongs to started timers alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.head) |-> (res_q.kind == KIND_STARTED))
    else $error("head flag on a result that is not a start");

  // An accepted item never yields a result in the same cycle it is taken, so
  // a final result directly follows another only if busy was low at the first.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.last) |=> !(res_valid_q && res_q.last && $past(busy)))
    else $error("two final results back to back from one busy period");

endmodule
